>>> sv/crc32_word_stream_assert.svh
// Assertion macros used by the checker of the word-stream CRC block.
`ifndef CRC32_WORD_STREAM_ASSERT_SVH
`define CRC32_WORD_STREAM_ASSERT_SVH

// Check on every rising clock edge, quiet while reset is high.
`define CRC32WS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, including those in reset.
`define CRC32WS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/crc32ws_pkg.sv
`default_nettype none

package crc32ws_pkg;

   localparam int unsigned CrcWidth = 32;
   localparam logic [CrcWidth-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam int unsigned BytesPerWord = 4;

   typedef logic [CrcWidth-1:0] crc_type;
   typedef logic [CrcWidth-1:0][CrcWidth-1:0] crc_cols_type;

   // Bit-serial form of one word update, MSB first per byte, low byte first.
   // Used only to build the constant update matrices below.
   function automatic crc_type crc_word_serial(input crc_type crc_in, input crc_type word);
      crc_type crc;
      crc = crc_in;
      for (int b = 0; b < BytesPerWord; b++) begin
         crc = crc ^ {word[8*b +: 8], 24'h00_0000};
         for (int k = 0; k < 8; k++) begin
            if (crc[CrcWidth-1]) begin
               crc = (crc << 1) ^ CRC_POLY;
            end else begin
               crc = crc << 1;
            end
         end
      end
      return crc;
   endfunction

   // Column i: effect of remainder bit i on the next remainder.
   function automatic crc_cols_type build_state_cols();
      crc_cols_type cols;
      for (int i = 0; i < CrcWidth; i++) begin
         cols[i] = crc_word_serial(crc_type'(1) << i, '0);
      end
      return cols;
   endfunction

   // Column j: effect of data bit j on the next remainder.
   function automatic crc_cols_type build_data_cols();
      crc_cols_type cols;
      for (int j = 0; j < CrcWidth; j++) begin
         cols[j] = crc_word_serial('0, crc_type'(1) << j);
      end
      return cols;
   endfunction

   localparam crc_cols_type STATE_COLS = build_state_cols();
   localparam crc_cols_type DATA_COLS  = build_data_cols();

   // Parallel word update: XOR of the columns selected by the set bits.
   function automatic crc_type crc_word_update(input crc_type crc_in, input crc_type word);
      crc_type acc;
      acc = '0;
      for (int i = 0; i < CrcWidth; i++) begin
         if (crc_in[i]) begin
            acc = acc ^ STATE_COLS[i];
         end
         if (word[i]) begin
            acc = acc ^ DATA_COLS[i];
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

>>> sv/crc32_word_stream.sv
`default_nettype none

// CRC-32 over a stream of 32-bit words: polynomial 04C11DB7, not reflected,
// initial value zero, no final XOR. Each word counts as four bytes, least
// significant byte first, each byte MSB first. Mark the first word of a
// message with req_first_word to restart the remainder at zero; mark the
// final word with req_last_word to get one result transaction carrying the
// CRC of the whole message, after which the remainder is zero again (so a
// message that follows without a first mark also starts from zero). Words
// with neither mark just advance the remainder. The block takes one word per
// clock cycle while req_stall is low. A last word is registered in the input
// register, then its result in the result register. The update is combinational:
// a constant 64-by-32 XOR matrix between the input register and the
// remainder/result registers. While a result waits on rsp_stall, words that
// are not marked last keep flowing; only a following last word stalls the
// input, for as long as the result register stays occupied.
module crc32_word_stream
   import crc32ws_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_crc_value
);

   // Input register.
   logic    s0_valid_ff, s0_valid_in;
   crc_type s0_word_ff;
   logic    s0_first_ff;
   logic    s0_last_ff;

   // Running remainder and result register.
   crc_type rem_ff, rem_in;
   logic    rsp_valid_ff, rsp_valid_in;
   crc_type rsp_crc_ff;

   logic    s0_hold;
   logic    s0_fire;
   logic    req_take;
   crc_type crc_base;
   crc_type crc_next;

   // A last word can only leave when the result register is free or is
   // being drained in this cycle; other words never wait.
   assign s0_hold  = s0_valid_ff && s0_last_ff && rsp_valid_ff && rsp_stall;
   assign s0_fire  = s0_valid_ff && !s0_hold;
   assign req_stall = s0_hold;
   assign req_take  = req_valid && !s0_hold;

   // First mark drops the partial remainder before the word is applied.
   assign crc_base = s0_first_ff ? '0 : rem_ff;
   assign crc_next = crc_word_update(crc_base, s0_word_ff);

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (!s0_hold) begin
         s0_valid_in = req_valid;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (s0_fire) begin
         rem_in = s0_last_ff ? '0 : crc_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s0_fire && s0_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on acceptance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_word_ff  <= req_data_word;
         s0_first_ff <= req_first_word;
         s0_last_ff  <= req_last_word;
      end
      if (s0_fire && s0_last_ff) begin
         rsp_crc_ff <= crc_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule

`default_nettype wire

>>> sv/crc32ws_checker.sv
`default_nettype none

`include "crc32_word_stream_assert.svh"

module crc32ws_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [31:0] req_data_word,
   input wire logic        req_first_word,
   input wire logic        req_last_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_crc_value
);

   logic zero_single_take;

   assign zero_single_take = req_valid && !req_stall && req_first_word && req_last_word
                             && (req_data_word == 32'h0000_0000);

   // A held result keeps its value.
   `CRC32WS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value), "result changed while stalled")

   // Input backpressure only comes from a blocked result.
   `CRC32WS_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "input stalled without a blocked result")

   // A one-word all-zero message yields CRC zero once it leaves the input register, if not blocked.
   `CRC32WS_ASSERT(a_zero_msg, zero_single_take ##1 !(rsp_valid && rsp_stall) |=> rsp_valid && (rsp_crc_value == 32'h0000_0000), "zero message gave wrong result")

   // Reset leaves no result pending and no backpressure.
   `CRC32WS_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind crc32_word_stream crc32ws_checker u_crc32ws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_data_word  (req_data_word),
   .req_first_word (req_first_word),
   .req_last_word  (req_last_word),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_crc_value  (rsp_crc_value)
);

`default_nettype wire

>>> test/crc32_word_stream_checker.sv
`timescale 1ns / 1ps

// Watches both channels of crc32_word_stream, predicts the CRC of every
// message and compares each result transaction against the oldest prediction.
module crc32_word_stream_checker
   import crc32ws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [31:0]       req_data_word,
   input  logic              req_first_word,
   input  logic              req_last_word,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [31:0]       rsp_crc_value,
   output int unsigned       fail_count,
   output int unsigned       pending_results,
   output int unsigned       results_checked
);

   localparam int unsigned MaxPrinted = 40;

   logic [31:0] running_crc;
   logic [31:0] crc_expected_q[$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
      running_crc     = '0;
   end

   // Bitwise form: feed bits MSB first within each byte, low byte first.
   function automatic logic [31:0] crc_advance_word(input logic [31:0] crc_in,
                                                    input logic [31:0] word);
      logic [31:0] crc;
      logic        feedback;
      crc = crc_in;
      for (int b = 0; b < 4; b++) begin
         for (int k = 7; k >= 0; k--) begin
            feedback = crc[31] ^ word[8*b + k];
            crc      = {crc[30:0], 1'b0} ^ (feedback ? CRC_POLY : 32'h0);
         end
      end
      return crc;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < MaxPrinted) begin
         $display("mismatch at %0t: %s (expected %08h, got %08h)", $realtime, what, want, got);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [31:0] next_crc;
      if (reset) begin
         running_crc = '0;
      end else begin
         // Results trail their last word through the input register, so compare first.
         if (rsp_valid && !rsp_stall) begin
            if (crc_expected_q.size() == 0) begin
               report_mismatch("crc_value with no message pending", 32'h0, rsp_crc_value);
            end else begin
               if (rsp_crc_value !== crc_expected_q[0]) begin
                  report_mismatch("crc_value", crc_expected_q[0], rsp_crc_value);
               end
               void'(crc_expected_q.pop_front());
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            next_crc = crc_advance_word(req_first_word ? 32'h0 : running_crc, req_data_word);
            if (req_last_word) begin
               crc_expected_q.push_back(next_crc);
               running_crc = '0;
            end else begin
               running_crc = next_crc;
            end
         end
         pending_results = crc_expected_q.size();
      end
   end

endmodule

>>> test/crc32_word_stream_tb.sv
`timescale 1ns / 1ps

// Top of the testbench: drives word transactions into the block, stalls the
// result channel on its own pattern, and reports the verdict from the
// checker's counts.
module crc32_word_stream_tb;

   localparam int unsigned RandomItems = 1050;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned TailCycles  = 12;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word  = '0;
   logic        req_first_word = 1'b0;
   logic        req_last_word  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_crc_value;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned results_checked;

   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned drain_count = 0;
   int unsigned cycle_count = 0;

   // Receiver stall pattern state.
   int unsigned stall_mode  = 0;
   int unsigned mode_left   = 0;
   int unsigned run_left    = 0;
   logic        run_level   = 1'b0;

   always #5 clock = ~clock;

   crc32_word_stream u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_first_word (req_first_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crc_value  (rsp_crc_value)
   );

   crc32_word_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_crc_value   (rsp_crc_value),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // Watchdog: end the run as failed once the cycle count passes CycleLimit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_results);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result-side stall: switch among free-flowing, light, heavy and long-run
   // modes so that stalls land on every phase of the block's work.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               run_level = ~run_level;
               run_left  = $urandom_range(1, 25);
            end
            run_left--;
            rsp_stall <= run_level;
         end
      endcase
   end

   // Random words half the time, with extremes and single-bit patterns mixed in.
   function automatic logic [31:0] pick_word();
      logic [31:0] one_hot;
      one_hot = 32'h1 << $urandom_range(0, 31);
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return one_hot;
         3: return ~one_hot;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_burst();
      // Now and then a long stretch with no idling at all.
      return ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
   endfunction

   // Offer one word transaction and hold it until accepted. The gap between
   // bursts goes in front of the word so valid never drops and rises in one step.
   task automatic send_word(input logic [31:0] word, input logic first, input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = pick_burst();
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_first_word <= first;
      req_last_word  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      burst_left = pick_burst();
      drain_count++;
   endtask

   initial begin
      int unsigned next_drain;
      int unsigned msg_kind;
      int unsigned msg_len;
      logic        first;
      logic        last;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = 64;
      @(negedge clock);

      // Directed part. Start without a first mark: the remainder is zero
      // out of reset, so the word applies to zero.
      send_word(32'h0000_0001, 1'b0, 1'b0);
      send_word(32'hDEAD_BEEF, 1'b0, 1'b1);
      // Single-word messages over the extremes of the data word.
      send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_word(32'h0000_0000, 1'b1, 1'b1);
      send_word(32'h8000_0000, 1'b1, 1'b1);
      send_word(32'h0000_0001, 1'b1, 1'b1);
      // Restart after a result with no first mark.
      send_word(32'h1234_5678, 1'b0, 1'b1);
      // Multi-word message with unmarked middle words.
      send_word(32'hA5A5_A5A5, 1'b1, 1'b0);
      send_word(32'h5A5A_5A5A, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_word(32'h0000_0000, 1'b0, 1'b1);
      // A repeated first mark drops the partial remainder.
      send_word(32'h1111_1111, 1'b1, 1'b0);
      send_word(32'h2222_2222, 1'b0, 1'b0);
      send_word(32'h3333_3333, 1'b1, 1'b0);
      send_word(32'h4444_4444, 1'b0, 1'b1);
      // Back-to-back last words press on the result register.
      send_word(32'hCAFE_F00D, 1'b1, 1'b1);
      send_word(32'h0BAD_C0DE, 1'b1, 1'b1);
      send_word(32'h00FF_00FF, 1'b0, 1'b1);
      send_word(32'hFF00_FF00, 1'b1, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      drain_results();

      // Random part: mostly well-formed messages, plus noise flags, mid-message
      // restarts and messages missing their first mark.
      next_drain = items_sent + 300;
      while (items_sent < RandomItems) begin
         msg_kind = $urandom_range(0, 9);
         msg_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         for (int i = 0; i < msg_len; i++) begin
            first = (i == 0);
            last  = (i == msg_len - 1);
            case (msg_kind)
               7: begin
                  first = 1'($urandom_range(0, 1));
                  last  = 1'($urandom_range(0, 1));
               end
               8: if (i != 0 && $urandom_range(0, 2) == 0) first = 1'b1;
               9: first = 1'b0;
               default: ;
            endcase
            send_word(pick_word(), first, last);
         end
         if (items_sent >= next_drain) begin
            drain_results();
            next_drain = items_sent + 300;
         end
      end

      // Drain, then allow the pipeline tail to flush out any stray result.
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);

      $display("sent %0d word transactions, compared %0d CRC results, %0d full drains",
               items_sent, results_checked, drain_count);
      $display("mix: single and multi-word messages, restarts, unmarked starts, noise flags");
      if (fail_count == 0 && pending_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_results);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/crc32ws_pkg.sv
sv/crc32_word_stream.sv
sv/crc32ws_checker.sv
test/crc32_word_stream_checker.sv
test/crc32_word_stream_tb.sv
